### design/bsts_pkg.sv
// shared types, widths and constants for the book skew trade signal block
package bsts_pkg;

  // default parameter values
  localparam int unsigned TotalWidthDef = 48;
  localparam int unsigned PriceWidthDef = 24;

  // fixed field widths
  localparam int unsigned DepthW   = 32;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned PosW     = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PnlW     = 48;
  localparam int unsigned SideW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // shared multiplier operand and product widths
  localparam int unsigned MulAW = 32;
  localparam int unsigned MulBW = 16;
  localparam int unsigned MulPW = MulAW + MulBW;

  // register reset values
  localparam logic [RatioW-1:0] DepthRatioRst = 16'd12831;
  localparam logic [LimitW-1:0] PosLimitRst   = 7'd50;
  localparam logic [ValueW-1:0] PointValueRst = 16'd5;
  localparam logic [ValueW-1:0] FeeRst        = 16'd52;

  // trade side codes
  typedef enum logic [SideW-1:0] {
    SIDE_NONE = 2'd0,
    SIDE_BUY  = 2'd1,
    SIDE_SELL = 2'd2
  } side_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH_RATIO = 2'd0,
    CFG_POS_LIMIT   = 2'd1,
    CFG_POINT_VALUE = 2'd2,
    CFG_FEE         = 2'd3
  } cfg_idx_e;

  // sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO_ASK,
    ST_RATIO_BID,
    ST_MARK,
    ST_DIFF,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_FINISH
  } bsts_state_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_ASK_RATIO,
    MUL_BID_RATIO,
    MUL_MARK,
    MUL_SCALE_LO,
    MUL_SCALE_HI
  } mul_sel_e;

endpackage

### design/bsts_mul.sv
// shared 32x16 multiplier with operand selection for every product of an update
module bsts_mul import bsts_pkg::*; #(
  parameter int unsigned TOTAL_WIDTH = TotalWidthDef,
  parameter int unsigned PRICE_WIDTH = PriceWidthDef
) (
  input  mul_sel_e                sel_i,
  input  logic [DepthW-1:0]       bid_depth_i,
  input  logic [DepthW-1:0]       ask_depth_i,
  input  logic [RatioW-1:0]       ratio_i,
  input  logic [PRICE_WIDTH-1:0]  price_i,
  input  logic [PosW-1:0]         mag_i,
  input  logic [ValueW-1:0]       point_value_i,
  input  logic [TOTAL_WIDTH-1:0]  diff_i,
  output logic [MulPW-1:0]        prod_o
);

  logic [MulAW-1:0] op_a;
  logic [MulBW-1:0] op_b;

  // operand mux
  always_comb begin
    unique case (sel_i)
      MUL_ASK_RATIO: begin
        op_a = ask_depth_i;
        op_b = ratio_i;
      end
      MUL_BID_RATIO: begin
        op_a = bid_depth_i;
        op_b = ratio_i;
      end
      MUL_MARK: begin
        op_a = MulAW'(price_i);
        op_b = MulBW'(mag_i);
      end
      MUL_SCALE_LO: begin
        op_a = MulAW'(diff_i);
        op_b = point_value_i;
      end
      MUL_SCALE_HI: begin
        op_a = MulAW'(diff_i >> 32);
        op_b = point_value_i;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // unsigned product
  assign prod_o = MulPW'(op_a) * MulPW'(op_b);

endmodule

### design/book_skew_trade_signal_pnl_top.sv
// top level of the book skew trade signal and marked-to-market pnl block
//
// Usage: book updates enter on the in_valid_i / in_ready_o channel, one
// result per update leaves on the out_valid_o / out_ready_i channel. A
// transfer happens at a clock edge where valid and ready are both high.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must write them only while the block is idle, the block does not enforce
// it. A write takes effect at the next edge. One update occupies the block for
// its accept plus seven steps, because a single 32x16 multiplier forms the two
// ratio products, the mark product and the two halves of the point value
// scaling in turn; out_valid_o rises once the last step passes the result on.
// in_ready_o is high only while the sequencer is idle. The result sits in an
// output register, so the next update is taken while a result waits; if the
// receiver still stalls when the next result is ready, the sequencer holds
// in its last step until the output register frees.
// Reset (rst_ni low) restores the register defaults, clears position,
// trade count, totals and the last reported pnl, and drops out_valid_o.
module book_skew_trade_signal_pnl_top import bsts_pkg::*; #(
  parameter int unsigned TOTAL_WIDTH = TotalWidthDef,
  parameter int unsigned PRICE_WIDTH = PriceWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  // book update channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DepthW-1:0]       bid_depth_i,
  input  logic [DepthW-1:0]       ask_depth_i,
  input  logic [PRICE_WIDTH-1:0]  best_bid_i,
  input  logic [PRICE_WIDTH-1:0]  best_ask_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SideW-1:0]        trade_side_o,
  output logic signed [PosW-1:0]  position_o,
  output logic [CountW-1:0]       units_traded_o,
  output logic signed [PnlW-1:0]  pnl_o,
  output logic                    pnl_changed_o
);

  bsts_state_e state_q, state_d;
  mul_sel_e    mul_sel;

  // configuration registers
  logic [RatioW-1:0] depth_ratio_q;
  logic [LimitW-1:0] pos_limit_q;
  logic [ValueW-1:0] point_value_q;
  logic [ValueW-1:0] fee_q;

  // running state
  logic signed [PosW-1:0]  pos_q;
  logic [CountW-1:0]       count_q;
  logic [TOTAL_WIDTH-1:0]  buy_tot_q;
  logic [TOTAL_WIDTH-1:0]  sell_tot_q;
  logic [TOTAL_WIDTH-1:0]  fee_tot_q;
  logic [TOTAL_WIDTH-1:0]  last_pnl_q;

  // captured update and working registers
  logic [DepthW-1:0]       bid_d_q;
  logic [DepthW-1:0]       ask_d_q;
  logic [PRICE_WIDTH-1:0]  bid_px_q;
  logic [PRICE_WIDTH-1:0]  ask_px_q;
  logic [MulPW-1:0]        prod_q;
  logic [TOTAL_WIDTH-1:0]  base_q;
  logic [TOTAL_WIDTH-1:0]  diff_q;
  logic [TOTAL_WIDTH-1:0]  acc_q;
  side_e                   side_q;

  // output register
  logic                    out_valid_q;
  logic [SideW-1:0]        out_side_q;
  logic signed [PosW-1:0]  out_pos_q;
  logic [CountW-1:0]       out_count_q;
  logic [PnlW-1:0]         out_pnl_q;
  logic                    out_changed_q;

  logic                    out_free;
  logic                    in_xfer;
  logic [MulPW-1:0]        mul_prod;
  logic [PRICE_WIDTH-1:0]  mark_price;
  logic [PosW-1:0]         mark_mag;
  logic signed [PosW-1:0]  lim_s;
  logic                    buy_hit;
  logic                    sell_hit;
  logic                    pos_long;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign pos_long = pos_q > 0;

  // mark price and position magnitude
  assign mark_price = pos_long ? bid_px_q : ask_px_q;
  assign mark_mag   = (pos_q < 0) ? PosW'(-pos_q) : PosW'(pos_q);

  // skew tests against the ratio products
  assign lim_s    = $signed({1'b0, pos_limit_q});
  assign buy_hit  = (MulPW'({bid_d_q, 8'b0}) > prod_q) && (pos_q < lim_s);
  assign sell_hit = (MulPW'({ask_d_q, 8'b0}) > mul_prod) && (pos_q > -lim_s);

  // shared multiplier
  bsts_mul #(
    .TOTAL_WIDTH (TOTAL_WIDTH),
    .PRICE_WIDTH (PRICE_WIDTH)
  ) u_mul (
    .sel_i         (mul_sel),
    .bid_depth_i   (bid_d_q),
    .ask_depth_i   (ask_d_q),
    .ratio_i       (depth_ratio_q),
    .price_i       (mark_price),
    .mag_i         (mark_mag),
    .point_value_i (point_value_q),
    .diff_i        (diff_q),
    .prod_o        (mul_prod)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_RATIO_ASK;
      ST_RATIO_ASK: state_d = ST_RATIO_BID;
      ST_RATIO_BID: state_d = ST_MARK;
      ST_MARK:      state_d = ST_DIFF;
      ST_DIFF:      state_d = ST_SCALE_LO;
      ST_SCALE_LO:  state_d = ST_SCALE_HI;
      ST_SCALE_HI:  state_d = ST_FINISH;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    mul_sel    = MUL_ASK_RATIO;
    unique case (state_q)
      ST_IDLE:      in_ready_o = 1'b1;
      ST_RATIO_ASK: mul_sel = MUL_ASK_RATIO;
      ST_RATIO_BID: mul_sel = MUL_BID_RATIO;
      ST_MARK:      mul_sel = MUL_MARK;
      ST_SCALE_LO:  mul_sel = MUL_SCALE_LO;
      ST_SCALE_HI:  mul_sel = MUL_SCALE_HI;
      default:      mul_sel = MUL_ASK_RATIO;
    endcase
  end

  // control, configuration and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      depth_ratio_q <= DepthRatioRst;
      pos_limit_q   <= PosLimitRst;
      point_value_q <= PointValueRst;
      fee_q         <= FeeRst;
      pos_q         <= '0;
      count_q       <= '0;
      buy_tot_q     <= '0;
      sell_tot_q    <= '0;
      fee_tot_q     <= '0;
      last_pnl_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEPTH_RATIO: depth_ratio_q <= cfg_data_i[RatioW-1:0];
          CFG_POS_LIMIT:   pos_limit_q   <= cfg_data_i[LimitW-1:0];
          CFG_POINT_VALUE: point_value_q <= cfg_data_i[ValueW-1:0];
          CFG_FEE:         fee_q         <= cfg_data_i[ValueW-1:0];
          default: ;
        endcase
      end
      // trade decision, buy test first
      if (state_q == ST_RATIO_BID) begin
        if (buy_hit) begin
          pos_q     <= pos_q + PosW'(1);
          count_q   <= count_q + CountW'(1);
          buy_tot_q <= buy_tot_q + TOTAL_WIDTH'(ask_px_q);
          fee_tot_q <= fee_tot_q + TOTAL_WIDTH'(fee_q);
        end else if (sell_hit) begin
          pos_q      <= pos_q - PosW'(1);
          count_q    <= count_q + CountW'(1);
          sell_tot_q <= sell_tot_q + TOTAL_WIDTH'(bid_px_q);
          fee_tot_q  <= fee_tot_q + TOTAL_WIDTH'(fee_q);
        end
      end
      // result transfer bookkeeping
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
        last_pnl_q  <= acc_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bid_d_q  <= bid_depth_i;
      ask_d_q  <= ask_depth_i;
      bid_px_q <= best_bid_i;
      ask_px_q <= best_ask_i;
    end
    unique case (state_q)
      ST_RATIO_ASK: prod_q <= mul_prod;
      ST_RATIO_BID: begin
        if (buy_hit) begin
          side_q <= SIDE_BUY;
        end else if (sell_hit) begin
          side_q <= SIDE_SELL;
        end else begin
          side_q <= SIDE_NONE;
        end
      end
      ST_MARK: begin
        prod_q <= mul_prod;
        base_q <= sell_tot_q - buy_tot_q;
      end
      ST_DIFF: begin
        diff_q <= pos_long ? base_q + TOTAL_WIDTH'(prod_q) : base_q - TOTAL_WIDTH'(prod_q);
        acc_q  <= '0 - fee_tot_q;
      end
      ST_SCALE_LO: acc_q <= acc_q + TOTAL_WIDTH'(mul_prod);
      ST_SCALE_HI: acc_q <= acc_q + TOTAL_WIDTH'({mul_prod, 32'b0});
      ST_FINISH: begin
        if (out_free) begin
          out_side_q    <= side_q;
          out_pos_q     <= pos_q;
          out_count_q   <= count_q;
          out_pnl_q     <= PnlW'(acc_q);
          out_changed_q <= acc_q != last_pnl_q;
        end
      end
      default: ;
    endcase
  end

  // result ports
  assign out_valid_o    = out_valid_q;
  assign trade_side_o   = out_side_q;
  assign position_o     = out_pos_q;
  assign units_traded_o = out_count_q;
  assign pnl_o          = $signed(out_pnl_q);
  assign pnl_changed_o  = out_changed_q;

endmodule

### tb/tb_book_skew_trade_signal_pnl_top.sv
// self-checking bench for the book skew trade signal block, with its own trade and pnl predictor
module tb_book_skew_trade_signal_pnl_top;
  import bsts_pkg::*;

  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseUpdates  = 275;

  localparam logic [DepthW-1:0]         DepthMax = '1;
  localparam logic [PriceWidthDef-1:0]  PriceMax = '1;

  // one book update and the result it should produce
  typedef struct packed {
    logic [DepthW-1:0]        bid_depth;
    logic [DepthW-1:0]        ask_depth;
    logic [PriceWidthDef-1:0] best_bid;
    logic [PriceWidthDef-1:0] best_ask;
  } book_update_t;

  typedef struct packed {
    side_e                side;
    logic signed [PosW-1:0] position;
    logic [CountW-1:0]    units_traded;
    logic [PnlW-1:0]      pnl;
    logic                 changed;
  } trade_result_t;

  // kinds of random book shape
  typedef enum int unsigned {
    BOOK_LEANING,
    BOOK_THRESHOLD,
    BOOK_NOISE,
    BOOK_EMPTY
  } book_shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i  = CFG_DEPTH_RATIO;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [DepthW-1:0]        bid_depth_i = '0;
  logic [DepthW-1:0]        ask_depth_i = '0;
  logic [PriceWidthDef-1:0] best_bid_i  = '0;
  logic [PriceWidthDef-1:0] best_ask_i  = '0;

  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [SideW-1:0]       trade_side_o;
  logic signed [PosW-1:0] position_o;
  logic [CountW-1:0]      units_traded_o;
  logic signed [PnlW-1:0] pnl_o;
  logic                   pnl_changed_o;

  book_skew_trade_signal_pnl_top u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .bid_depth_i,
    .ask_depth_i,
    .best_bid_i,
    .best_ask_i,
    .out_valid_o,
    .out_ready_i,
    .trade_side_o,
    .position_o,
    .units_traded_o,
    .pnl_o,
    .pnl_changed_o
  );

  // predictor registers and state
  logic [RatioW-1:0]       ratio_q8   = DepthRatioRst;
  logic [LimitW-1:0]       pos_limit  = PosLimitRst;
  logic [ValueW-1:0]       point_val  = PointValueRst;
  logic [ValueW-1:0]       fee_unit   = FeeRst;
  logic signed [PosW-1:0]  net_pos    = '0;
  logic [CountW-1:0]       n_bought   = '0;
  logic [CountW-1:0]       n_sold     = '0;
  logic [PnlW-1:0]         buy_total  = '0;
  logic [PnlW-1:0]         sell_total = '0;
  logic [PnlW-1:0]         fee_total  = '0;
  logic [PnlW-1:0]         last_pnl   = '0;

  book_update_t  book_updates[$];
  trade_result_t pending_results[$];
  book_update_t  cur_update = '0;

  int unsigned in_calm     = 100;
  int unsigned out_calm    = 100;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches  = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // wait cycles for one item; calm_pct is the share of items with no wait
  function automatic int unsigned pick_gap(int unsigned calm_pct);
    if ($urandom_range(0, 99) < calm_pct) return 0;
    return $urandom_range(0, 14);
  endfunction

  // trade decision, position, totals and marked pnl for one update
  function automatic trade_result_t apply_book_update(book_update_t u);
    logic [63:0] bid_w, ask_w, mark_sell, mark_buy, diff, scaled;
    int pos_n, lim_n;
    trade_result_t r;
    bid_w     = 64'(u.bid_depth);
    ask_w     = 64'(u.ask_depth);
    pos_n     = int'(net_pos);
    lim_n     = int'(pos_limit);
    mark_sell = '0;
    mark_buy  = '0;
    r.side    = SIDE_NONE;
    // buy test has priority over sell test
    if ((bid_w << 8) > ask_w * 64'(ratio_q8) && pos_n < lim_n) begin
      net_pos   = net_pos + 8'sd1;
      n_bought  = n_bought + 1;
      buy_total = buy_total + PnlW'(u.best_ask);
      fee_total = fee_total + PnlW'(fee_unit);
      r.side    = SIDE_BUY;
    end else if ((ask_w << 8) > bid_w * 64'(ratio_q8) && pos_n > -lim_n) begin
      net_pos    = net_pos - 8'sd1;
      n_sold     = n_sold + 1;
      sell_total = sell_total + PnlW'(u.best_bid);
      fee_total  = fee_total + PnlW'(fee_unit);
      r.side     = SIDE_SELL;
    end
    // mark open position: long at the bid, short at the ask
    pos_n = int'(net_pos);
    if (pos_n > 0) mark_sell = 64'(u.best_bid) * 64'(pos_n);
    else if (pos_n < 0) mark_buy = 64'(u.best_ask) * 64'(-pos_n);
    diff   = 64'(sell_total) + mark_sell - 64'(buy_total) - mark_buy;
    scaled = 64'(point_val) * diff - 64'(fee_total);
    r.position     = net_pos;
    r.units_traded = n_bought + n_sold;
    r.pnl          = scaled[PnlW-1:0];
    r.changed      = (scaled[PnlW-1:0] != last_pnl);
    last_pnl       = scaled[PnlW-1:0];
    return r;
  endfunction

  function automatic logic [PriceWidthDef-1:0] random_price();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return PriceMax;
    return PriceWidthDef'($urandom);
  endfunction

  // random update; bid_bias is the chance in percent that the bid side leans heavy
  function automatic book_update_t random_update(int unsigned bid_bias);
    book_update_t u;
    book_shape_e shape;
    int unsigned roll;
    logic [63:0] base, lean;
    logic bid_heavy;
    roll      = $urandom_range(0, 99);
    bid_heavy = ($urandom_range(0, 99) < bid_bias);
    shape     = (roll < 75) ? BOOK_LEANING :
                (roll < 87) ? BOOK_THRESHOLD :
                (roll < 95) ? BOOK_NOISE : BOOK_EMPTY;
    u.best_bid = random_price();
    u.best_ask = random_price();
    base = '0;
    lean = '0;
    case (shape)
      BOOK_LEANING: begin
        base = 64'($urandom) >> $urandom_range(0, 31);
        lean = ((base * 64'(ratio_q8)) >> 8) + 64'($urandom_range(1, 2000));
        if (lean > 64'(DepthMax)) lean = 64'(DepthMax);
      end
      BOOK_THRESHOLD: begin
        // light side a multiple of 256 so the product lands exactly on the threshold
        lean = 64'($urandom_range(0, 65535));
        base = lean << 8;
        lean = lean * 64'(ratio_q8) + 64'($urandom_range(0, 2));
        lean = (lean == 0) ? 64'd0 : lean - 1;
      end
      BOOK_NOISE: begin
        base = 64'($urandom >> $urandom_range(0, 31));
        lean = 64'($urandom >> $urandom_range(0, 31));
      end
      default: begin
        base = '0;
        lean = $urandom_range(0, 1) ? 64'($urandom) : 64'd0;
      end
    endcase
    if (bid_heavy) begin
      u.bid_depth = lean[DepthW-1:0];
      u.ask_depth = base[DepthW-1:0];
    end else begin
      u.bid_depth = base[DepthW-1:0];
      u.ask_depth = lean[DepthW-1:0];
    end
    return u;
  endfunction

  task automatic add_update(logic [DepthW-1:0] bid_d, logic [DepthW-1:0] ask_d,
                            logic [PriceWidthDef-1:0] bid_px,
                            logic [PriceWidthDef-1:0] ask_px);
    book_update_t u;
    u.bid_depth = bid_d;
    u.ask_depth = ask_d;
    u.best_bid  = bid_px;
    u.best_ask  = ask_px;
    book_updates.push_back(u);
  endtask

  // wait until every update is taken and every result is back
  task automatic settle();
    while (book_updates.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_DEPTH_RATIO: ratio_q8  = data[RatioW-1:0];
      CFG_POS_LIMIT:   pos_limit = data[LimitW-1:0];
      CFG_POINT_VALUE: point_val = data[ValueW-1:0];
      CFG_FEE:         fee_unit  = data[ValueW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [CfgDataW-1:0] ratio, logic [CfgDataW-1:0] limit,
                          logic [CfgDataW-1:0] value, logic [CfgDataW-1:0] fee);
    write_reg(CFG_DEPTH_RATIO, ratio);
    write_reg(CFG_POS_LIMIT, limit);
    write_reg(CFG_POINT_VALUE, value);
    write_reg(CFG_FEE, fee);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // update driver: one transfer per item, random gap after each
  always @(posedge clk_i) begin : update_driver
    book_update_t nxt;
    trade_result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        res = apply_book_update(cur_update);
        pending_results.push_back(res);
      end
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (book_updates.size() != 0) begin
        nxt = book_updates.pop_front();
        cur_update  <= nxt;
        bid_depth_i <= nxt.bid_depth;
        ask_depth_i <= nxt.ask_depth;
        best_bid_i  <= nxt.best_bid;
        best_ask_i  <= nxt.best_ask;
        in_valid_i  <= 1'b1;
        in_gap      <= pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor, receiver stalls and watchdog
  always @(posedge clk_i) begin : result_monitor
    int unsigned stall;
    trade_result_t exp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
      idle_cycles <= 0;
    end else begin
      stall = out_stall;
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $error("result transfer with no result pending");
        end else begin
          exp = pending_results.pop_front();
          if (trade_side_o !== exp.side) begin
            mismatches++;
            $error("trade_side: expected %0d, got %0d", exp.side, trade_side_o);
          end
          if (position_o !== exp.position) begin
            mismatches++;
            $error("position: expected %0d, got %0d", exp.position, position_o);
          end
          if (units_traded_o !== exp.units_traded) begin
            mismatches++;
            $error("units_traded: expected %0d, got %0d", exp.units_traded,
                   units_traded_o);
          end
          if (pnl_o !== exp.pnl) begin
            mismatches++;
            $error("pnl: expected %0d, got %0d", $signed(exp.pnl), pnl_o);
          end
          if (pnl_changed_o !== exp.changed) begin
            mismatches++;
            $error("pnl_changed: expected %0d, got %0d", exp.changed, pnl_changed_o);
          end
        end
        stall = pick_gap(out_calm);
      end else if (stall != 0) begin
        stall--;
      end
      out_stall   <= stall;
      out_ready_i <= (stall == 0);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus: directed corners, then random phases under varied settings
  initial begin : stimulus
    int unsigned bias;
    logic [CfgDataW-1:0] ratio, limit, value, fee;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty book, one-sided books, exact thresholds
    add_update('0, '0, '0, '0);
    add_update(DepthMax, '0, PriceMax, PriceMax);
    add_update('0, DepthMax, '0, '0);
    add_update(DepthMax, DepthMax, PriceMax, '0);
    add_update(32'd12831, 32'd256, 24'd1000, 24'd1001);
    add_update(32'd12832, 32'd256, 24'd1000, 24'd1001);
    add_update(32'd256, 32'd12832, 24'd2000, 24'd2002);
    add_update(32'd256, 32'd12831, 24'd2000, 24'd2002);
    add_update(32'd1, '0, '0, PriceMax);
    add_update('0, 32'd1, PriceMax, '0);
    settle();

    // ratio below one with a tiny limit: both tests hold, buy wins until the limit
    set_regs(16'd1, 16'hFF82, 16'hFFFF, 16'hFFFF);
    repeat (4) add_update(32'd5, 32'd5, PriceMax, 24'h800000);
    repeat (5) add_update('0, 32'd100, 24'h123456, PriceMax);
    settle();

    // largest ratio, zero limit, zero point value and fee
    set_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    add_update(DepthMax, 32'd1, 24'h00FFFF, 24'hFF0000);
    add_update(32'd1, DepthMax, 24'hAAAAAA, 24'h555555);
    add_update(DepthMax, DepthMax, PriceMax, PriceMax);
    add_update('0, '0, 24'd7, 24'd9);
    settle();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 6))
        0: ratio = 16'd1;
        1: ratio = 16'd255;
        2: ratio = 16'd256;
        3: ratio = 16'hFFFF;
        4: ratio = DepthRatioRst;
        default: ratio = CfgDataW'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 5))
        0: limit = 16'd0;
        1: limit = 16'd1;
        2: limit = 16'd3;
        3: limit = 16'd127;
        default: limit = CfgDataW'($urandom_range(0, 127));
      endcase
      // upper bits beyond the register width are dropped
      limit[CfgDataW-1:LimitW] = (CfgDataW - LimitW)'($urandom);
      case ($urandom_range(0, 3))
        0: value = 16'd0;
        1: value = 16'hFFFF;
        2: value = 16'd1;
        default: value = CfgDataW'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: fee = 16'd0;
        1: fee = 16'hFFFF;
        2: fee = 16'd1;
        default: fee = CfgDataW'($urandom);
      endcase
      // first random phase runs with a deep limit and no idling at all
      if (phase == 0) begin
        limit    = 16'd127;
        in_calm  = 100;
        out_calm = 100;
      end else begin
        in_calm  = 40 * $urandom_range(0, 2);
        out_calm = 40 * $urandom_range(0, 2);
      end
      set_regs(ratio, limit, value, fee);

      // lean one way, then the other, to reach both position limits
      case ($urandom_range(0, 3))
        0: bias = 10;
        1: bias = 90;
        2: bias = 50;
        default: bias = $urandom_range(0, 100);
      endcase
      for (int unsigned k = 0; k < PhaseUpdates; k++) begin
        if (k == PhaseUpdates / 2) bias = 100 - bias;
        book_updates.push_back(random_update(bias));
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
